// ----- hdl/tsk_pkg.sv -----
// Shared constants and codes for the Kahn topological sort block.
// No dependencies; used by the top level topological_sort_kahn.
package tsk_pkg;

    localparam int VTX_W = 6;  // width of a vertex number
    localparam int CNT_W = 7;  // width of the vertex count register

    localparam logic [CNT_W-1:0] VCOUNT_RESET = 7'd1;

    localparam logic ACT_ADD = 1'b0;
    localparam logic ACT_RUN = 1'b1;

endpackage

// ----- hdl/tsk_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the edge, in-degree and queue stores.
module tsk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/topological_sort_kahn.sv -----
// Top level of the Kahn topological sort block.
// Depends on tsk_pkg and tsk_ram.
//
// Edge beats (action add) are taken one per cycle while the block is idle and
// stored in arrival order; an edge naming a vertex at or above the vertex count,
// or arriving with the store full, is dropped and remembered in a flag. A run
// beat starts a sequencer that owns three single-port-read RAMs (edges,
// in-degrees and the ready queue) and walks them one access at a time, so the
// input is not ready until the run has ended, and the run also waits while the
// output is stalled. The run first clears the in-degrees, then counts them over
// the stored edges, then seeds the queue with every vertex of in-degree zero;
// every popped vertex then scans the whole edge store, decrementing the
// in-degree of each out-edge target. Each popped vertex becomes one output beat
// after its out-edges are processed, and the beat that empties the queue carries
// last, incomplete and edge_dropped. A run that emits nothing gives a single beat
// with has_vertex low. The run clears the edge store and the drop flag. The
// vertex count register may be written whenever the block is idle; values above
// MAX_VERTICES are treated as MAX_VERTICES.
module topological_sort_kahn #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [tsk_pkg::CNT_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      action,
    input  logic [tsk_pkg::VTX_W-1:0] src,
    input  logic [tsk_pkg::VTX_W-1:0] dst,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [tsk_pkg::VTX_W-1:0] vertex,
    output logic                      has_vertex,
    output logic                      last,
    output logic                      incomplete,
    output logic                      edge_dropped
);

    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EW  = $clog2(MAX_EDGES + 1);
    localparam int VAW = $clog2(MAX_VERTICES);
    localparam int CW  = tsk_pkg::CNT_W;
    localparam int VW  = tsk_pkg::VTX_W;
    localparam logic [CW-1:0] MAXV = CW'(MAX_VERTICES);
    localparam logic [EW-1:0] MAXE = EW'(MAX_EDGES);

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_CNT_RD, S_CNT_E, S_CNT_INC, S_SEED_RD, S_SEED_CHK,
        S_POP, S_POP_W, S_WALK_RD, S_WALK_E, S_WALK_D, S_EMIT
    } state_t;

    state_t         state_reg;
    logic [CW-1:0]  vcount_reg;
    logic [EW-1:0]  etotal_reg;
    logic           drop_reg;
    logic [CW-1:0]  i_reg;
    logic [EW-1:0]  e_reg;
    logic [CW-1:0]  head_reg;
    logic [CW-1:0]  tail_reg;
    logic [VW-1:0]  v_reg;
    logic [VW-1:0]  t_reg;
    logic           has_reg;

    logic           out_valid_reg;
    logic [VW-1:0]  vertex_reg;
    logic           has_out_reg;
    logic           last_reg;
    logic           inc_reg;
    logic           dropped_reg;

    logic [CW-1:0]  n;
    logic           in_fire;
    logic           add_bad;
    logic           out_free;

    logic           edge_we;
    logic [2*VW-1:0] edge_rdata;
    logic [VW-1:0]  e_src;
    logic [VW-1:0]  e_dst;

    logic           deg_we;
    logic [VAW-1:0] deg_waddr;
    logic [EW-1:0]  deg_wdata;
    logic [VAW-1:0] deg_raddr;
    logic [EW-1:0]  deg_rdata;

    logic           q_we;
    logic [VW-1:0]  q_wdata;
    logic [VW-1:0]  q_rdata;

    // The count register saturates at the vertex capacity when used.
    assign n         = (vcount_reg > MAXV) ? MAXV : vcount_reg;
    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign add_bad   = ({1'b0, src} >= n) || ({1'b0, dst} >= n) || (etotal_reg == MAXE);
    assign out_free  = !out_valid_reg || out_ready;

    assign e_src = edge_rdata[2*VW-1:VW];
    assign e_dst = edge_rdata[VW-1:0];

    assign edge_we = in_fire && (action == tsk_pkg::ACT_ADD) && !add_bad;

    tsk_ram #(.WIDTH(2 * VW), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (etotal_reg[EAW-1:0]),
        .wdata ({src, dst}),
        .raddr (e_reg[EAW-1:0]),
        .rdata (edge_rdata)
    );

    // In-degree and queue port control: cleared, incremented while counting, read while
    // seeding, and decremented while walking the out-edges of a popped vertex.
    always_comb
    begin
        deg_we    = 1'b0;
        deg_waddr = t_reg[VAW-1:0];
        deg_wdata = deg_rdata + EW'(1);
        deg_raddr = e_dst[VAW-1:0];
        q_we      = 1'b0;
        q_wdata   = t_reg;
        case (state_reg)
            S_CLR:
            begin
                deg_we    = 1'b1;
                deg_waddr = i_reg[VAW-1:0];
                deg_wdata = '0;
            end
            S_CNT_INC:
            begin
                deg_we = 1'b1;
            end
            S_SEED_RD:
            begin
                deg_raddr = i_reg[VAW-1:0];
            end
            S_SEED_CHK:
            begin
                q_we    = (deg_rdata == '0);
                q_wdata = i_reg[VW-1:0];
            end
            S_WALK_D:
            begin
                deg_we    = (deg_rdata != '0);
                deg_wdata = deg_rdata - EW'(1);
                q_we      = (deg_rdata == EW'(1));
            end
            default:
            begin
            end
        endcase
    end

    tsk_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_deg_ram (
        .clk   (clk),
        .we    (deg_we),
        .waddr (deg_waddr),
        .wdata (deg_wdata),
        .raddr (deg_raddr),
        .rdata (deg_rdata)
    );

    tsk_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (tail_reg[VAW-1:0]),
        .wdata (q_wdata),
        .raddr (head_reg[VAW-1:0]),
        .rdata (q_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vcount_reg    <= tsk_pkg::VCOUNT_RESET;
            etotal_reg    <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            e_reg         <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            v_reg         <= '0;
            t_reg         <= '0;
            has_reg       <= 1'b0;
            vertex_reg    <= '0;
            has_out_reg   <= 1'b0;
            last_reg      <= 1'b0;
            inc_reg       <= 1'b0;
            dropped_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                vcount_reg <= cfg_data;
            end
            // The emit state loads the output register itself.
            if (out_valid_reg && out_ready && (state_reg != S_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (action == tsk_pkg::ACT_ADD)
                        begin
                            if (add_bad)
                            begin
                                drop_reg <= 1'b1;
                            end
                            else
                            begin
                                etotal_reg <= etotal_reg + EW'(1);
                            end
                        end
                        else
                        begin
                            i_reg    <= '0;
                            e_reg    <= '0;
                            head_reg <= '0;
                            tail_reg <= '0;
                            state_reg <= (n == '0) ? S_POP : S_CLR;
                        end
                    end
                end
                S_CLR:
                begin
                    i_reg <= i_reg + CW'(1);
                    if (i_reg + CW'(1) == n)
                    begin
                        state_reg <= S_CNT_RD;
                    end
                end
                S_CNT_RD:
                begin
                    if (e_reg == etotal_reg)
                    begin
                        i_reg     <= '0;
                        state_reg <= S_SEED_RD;
                    end
                    else
                    begin
                        state_reg <= S_CNT_E;
                    end
                end
                S_CNT_E:
                begin
                    // Edges left over from a larger vertex count are skipped.
                    if (({1'b0, e_src} < n) && ({1'b0, e_dst} < n))
                    begin
                        t_reg     <= e_dst;
                        state_reg <= S_CNT_INC;
                    end
                    else
                    begin
                        e_reg     <= e_reg + EW'(1);
                        state_reg <= S_CNT_RD;
                    end
                end
                S_CNT_INC:
                begin
                    e_reg     <= e_reg + EW'(1);
                    state_reg <= S_CNT_RD;
                end
                S_SEED_RD:
                begin
                    state_reg <= S_SEED_CHK;
                end
                S_SEED_CHK:
                begin
                    if (deg_rdata == '0)
                    begin
                        tail_reg <= tail_reg + CW'(1);
                    end
                    i_reg <= i_reg + CW'(1);
                    state_reg <= (i_reg + CW'(1) == n) ? S_POP : S_SEED_RD;
                end
                S_POP:
                begin
                    if (head_reg == tail_reg)
                    begin
                        has_reg   <= 1'b0;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_POP_W;
                    end
                end
                S_POP_W:
                begin
                    v_reg     <= q_rdata;
                    has_reg   <= 1'b1;
                    head_reg  <= head_reg + CW'(1);
                    e_reg     <= '0;
                    state_reg <= S_WALK_RD;
                end
                S_WALK_RD:
                begin
                    state_reg <= (e_reg == etotal_reg) ? S_EMIT : S_WALK_E;
                end
                S_WALK_E:
                begin
                    if ((e_src == v_reg) && ({1'b0, e_dst} < n))
                    begin
                        t_reg     <= e_dst;
                        state_reg <= S_WALK_D;
                    end
                    else
                    begin
                        e_reg     <= e_reg + EW'(1);
                        state_reg <= S_WALK_RD;
                    end
                end
                S_WALK_D:
                begin
                    if (deg_rdata == EW'(1))
                    begin
                        tail_reg <= tail_reg + CW'(1);
                    end
                    e_reg     <= e_reg + EW'(1);
                    state_reg <= S_WALK_RD;
                end
                S_EMIT:
                begin
                    // After seeding the queue only grows during a walk, so an empty queue
                    // here means this beat ends the run.
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        vertex_reg    <= has_reg ? v_reg : '0;
                        has_out_reg   <= has_reg;
                        if (head_reg == tail_reg)
                        begin
                            last_reg    <= 1'b1;
                            inc_reg     <= (head_reg < n);
                            dropped_reg <= drop_reg;
                            etotal_reg  <= '0;
                            drop_reg    <= 1'b0;
                            state_reg   <= S_IDLE;
                        end
                        else
                        begin
                            last_reg    <= 1'b0;
                            inc_reg     <= 1'b0;
                            dropped_reg <= 1'b0;
                            state_reg   <= S_POP;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign vertex       = vertex_reg;
    assign has_vertex   = has_out_reg;
    assign last         = last_reg;
    assign incomplete   = inc_reg;
    assign edge_dropped = dropped_reg;

endmodule
